@@ rtl/tcw_pkg.sv @@
// Shared constants of the text console writer: control characters and register map.
package tcw_pkg;

    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_NUL       = 8'h00;

    localparam int         PADDR_W          = 3;
    localparam logic       REG_DEFAULT_ATTR = 1'b0;
    localparam logic [7:0] DEFAULT_ATTR_RST = 8'd15;

    localparam logic [1:0] OP_PRINT = 2'd0;

endpackage

@@ rtl/tcw_cfg_regs.sv @@
// APB register bank of the text console writer: the default attribute register.
module tcw_cfg_regs
    import tcw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [7:0]         default_attr
);

    logic [7:0] default_attr_reg;
    logic [7:0] default_attr_next;
    logic       wr_en;
    logic       sel_attr;

    // word index sits above the byte offset
    assign sel_attr = (paddr[PADDR_W-1] == REG_DEFAULT_ATTR);
    assign wr_en    = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_comb
    begin
        default_attr_next = default_attr_reg;
        if (wr_en && sel_attr)
        begin
            default_attr_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_attr_reg <= DEFAULT_ATTR_RST;
        end
        else
        begin
            default_attr_reg <= default_attr_next;
        end
    end

    assign prdata       = sel_attr ? {24'd0, default_attr_reg} : 32'd0;
    assign default_attr = default_attr_reg;

endmodule

@@ rtl/text_console_writer_core.sv @@
// Text console writer: character grid in one memory, cursor, scroll and cell readback.
//
// Input stream (s_axis_*): tuser selects the operation (0 prints a character,
// 1 reads one cell); tdata carries char_code, attr_in and cell_index. Output
// stream (m_axis_*): one transaction per input, carrying the cursor offset
// after the step and, for a read, the cell's character and attribute.
// Configuration over APB: default_attr at byte address 0.
//
// Items are handled one at a time around a single-port-per-direction cell
// memory with a registered read. A printable character, CR, LF or a backspace
// at column 0 finishes as it is accepted unless it scrolls; a read or a
// backspace reads the cell first, then returns it or writes it back. A scroll
// sweeps the whole grid through the memory, moving each row up by one and
// blanking the bottom row. After reset the grid is cleared by a pass over
// every cell during which no item is accepted; configuration writes are taken
// throughout. The result sits in an output register, so a new item is accepted
// while the previous result waits; if the receiver stalls, the next result is
// held inside until the output register frees up, and input acceptance stops.
module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input item
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [31:0]        s_axis_tdata,   // [7:0] char_code, [15:8] attr_in, [26:16] cell_index
    input  logic               s_axis_tuser,   // [0] op
    // result item
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [31:0]        m_axis_tdata,   // [10:0] cursor_offset, [18:11] cell_char, [26:19] cell_attr
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COPY_N = CELLS - COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int SCROLL_ADDR = (ROWS - 2) * COLUMNS;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_BS   = 3'd3;
    localparam logic [2:0] ST_SCR  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [7:0]        default_attr;

    logic [2:0]        state_reg,  state_next;
    logic [COL_W-1:0]  col_reg,    col_next;
    logic [ROW_W-1:0]  row_reg,    row_next;
    logic [ADDR_W-1:0] addr_reg,   addr_next;
    logic [CNT_W-1:0]  sweep_reg,  sweep_next;
    logic              hit_reg,    hit_next;
    logic [7:0]        res_char_reg, res_char_next;
    logic [7:0]        res_attr_reg, res_attr_next;
    logic              m_valid_reg, m_valid_next;
    logic [10:0]       m_curs_reg,  m_curs_next;
    logic [7:0]        m_char_reg,  m_char_next;
    logic [7:0]        m_attr_reg,  m_attr_next;

    logic [15:0]       cell_mem [0:CELLS-1];
    logic [15:0]       rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic              in_op;
    logic [7:0]        in_char;
    logic [7:0]        in_attr;
    logic [10:0]       in_index;
    logic              in_range;
    logic [7:0]        attr_eff;
    logic              accept;
    logic              out_free;
    logic              finish;
    logic              scroll_go;
    logic [7:0]        fin_char;
    logic [7:0]        fin_attr;
    logic [CNT_W-1:0]  sweep_dec;
    logic [CNT_W-1:0]  sweep_src;

    tcw_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .default_attr (default_attr)
    );

    assign in_op    = s_axis_tuser;
    assign in_char  = s_axis_tdata[7:0];
    assign in_attr  = s_axis_tdata[15:8];
    assign in_index = s_axis_tdata[26:16];
    assign in_range = (32'(in_index) < 32'(CELLS));
    assign attr_eff = ((in_attr == 8'd0) || in_attr[7]) ? default_attr : in_attr;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign sweep_dec = sweep_reg - CNT_W'(1);
    assign sweep_src = sweep_reg + CNT_W'(COLUMNS);

    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        addr_next     = addr_reg;
        sweep_next    = sweep_reg;
        hit_next      = hit_reg;
        res_char_next = res_char_reg;
        res_attr_next = res_attr_reg;
        m_valid_next  = m_valid_reg;
        m_curs_next   = m_curs_reg;
        m_char_next   = m_char_reg;
        m_attr_next   = m_attr_reg;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        mem_wdata     = 16'd0;
        mem_re        = 1'b0;
        mem_raddr     = addr_reg;
        finish        = 1'b0;
        scroll_go     = 1'b0;
        fin_char      = 8'd0;
        fin_attr      = 8'd0;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg[ADDR_W-1:0];
                if (sweep_reg == CNT_W'(CELLS - 1))
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + CNT_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_op != OP_PRINT[0])
                    begin
                        mem_re     = in_range;
                        mem_raddr  = ADDR_W'(in_index);
                        hit_next   = in_range;
                        state_next = ST_RD;
                    end
                    else
                    begin
                        case (in_char)
                            CH_BACKSPACE:
                            begin
                                if (col_reg != '0)
                                begin
                                    mem_re     = 1'b1;
                                    mem_raddr  = addr_reg - ADDR_W'(1);
                                    col_next   = col_reg - COL_W'(1);
                                    addr_next  = addr_reg - ADDR_W'(1);
                                    state_next = ST_BS;
                                end
                                else
                                begin
                                    finish = 1'b1;
                                end
                            end
                            CH_CR:
                            begin
                                col_next  = '0;
                                addr_next = addr_reg - ADDR_W'(col_reg);
                                finish    = 1'b1;
                            end
                            CH_LF:
                            begin
                                if (row_reg == ROW_W'(ROWS - 2))
                                begin
                                    scroll_go = 1'b1;
                                end
                                else
                                begin
                                    row_next  = row_reg + ROW_W'(1);
                                    col_next  = '0;
                                    addr_next = addr_reg - ADDR_W'(col_reg) + ADDR_W'(COLUMNS);
                                    finish    = 1'b1;
                                end
                            end
                            default:
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = addr_reg;
                                mem_wdata = {attr_eff, in_char};
                                addr_next = addr_reg + ADDR_W'(1);
                                if (col_reg == COL_W'(COLUMNS - 1))
                                begin
                                    col_next = '0;
                                    if (row_reg == ROW_W'(ROWS - 2))
                                    begin
                                        scroll_go = 1'b1;
                                    end
                                    else
                                    begin
                                        row_next = row_reg + ROW_W'(1);
                                        finish   = 1'b1;
                                    end
                                end
                                else
                                begin
                                    col_next = col_reg + COL_W'(1);
                                    finish   = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_RD:
            begin
                finish = 1'b1;
                if (hit_reg)
                begin
                    fin_char = rdata_reg[7:0];
                    fin_attr = rdata_reg[15:8];
                end
            end
            ST_BS:
            begin
                // keep the attribute, blank the character
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = {rdata_reg[15:8], CH_NUL};
                finish    = 1'b1;
            end
            ST_SCR:
            begin
                // read one row ahead, write the previous read one cell behind
                if (sweep_reg < CNT_W'(COPY_N))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = sweep_src[ADDR_W-1:0];
                end
                if (sweep_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = sweep_dec[ADDR_W-1:0];
                    mem_wdata = (sweep_dec < CNT_W'(COPY_N)) ? rdata_reg : 16'd0;
                end
                if (sweep_reg == CNT_W'(CELLS))
                begin
                    sweep_next = '0;
                    finish     = 1'b1;
                end
                else
                begin
                    sweep_next = sweep_reg + CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_curs_next  = 11'(addr_reg);
                    m_char_next  = res_char_reg;
                    m_attr_next  = res_attr_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (scroll_go)
        begin
            row_next   = ROW_W'(ROWS - 2);
            col_next   = '0;
            addr_next  = ADDR_W'(SCROLL_ADDR);
            sweep_next = '0;
            state_next = ST_SCR;
        end

        if (finish)
        begin
            res_char_next = fin_char;
            res_attr_next = fin_attr;
            if (out_free)
            begin
                m_valid_next = 1'b1;
                m_curs_next  = 11'(addr_next);
                m_char_next  = fin_char;
                m_attr_next  = fin_attr;
                state_next   = ST_IDLE;
            end
            else
            begin
                state_next = ST_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLR;
            col_reg     <= '0;
            row_reg     <= '0;
            addr_reg    <= '0;
            sweep_reg   <= '0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            addr_reg    <= addr_next;
            sweep_reg   <= sweep_next;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_char_reg <= res_char_next;
        res_attr_reg <= res_attr_next;
        m_curs_reg   <= m_curs_next;
        m_char_reg   <= m_char_next;
        m_attr_reg   <= m_attr_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= cell_mem[mem_raddr];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'd0, m_attr_reg, m_char_reg, m_curs_reg};

`ifndef SYNTHESIS
    a_row_below_last: assert property (@(posedge clk) disable iff (!rst_n)
        32'(row_reg) <= ROWS - 2)
        else $error("cursor row reached the last row");

    a_addr_tracks_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        32'(addr_reg) == 32'(row_reg) * COLUMNS + 32'(col_reg))
        else $error("cursor address out of step with row and column");

    a_read_goes_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_op) |=> (state_reg == ST_RD))
        else $error("read item did not enter the read state");

    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCR) |-> (32'(sweep_reg) <= CELLS))
        else $error("scroll sweep ran past the grid");

    a_no_write_in_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (!mem_we && !mem_re))
        else $error("memory access while a result is held");
`endif

endmodule
